@@ rtl/sbis_pkg.sv @@
// Package for the simulated bifurcation Ising solver.
// Types, codes and fixed-point constants; no dependencies.
package sbis_pkg;

  localparam int MaxSpinsDefault = 256;

  typedef enum logic [1:0] {
    REQ_LOAD_COUPLING = 2'd0,
    REQ_LOAD_SPIN     = 2'd1,
    REQ_RUN           = 2'd2,
    REQ_READ_SPIN     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    RES_RUN_DONE     = 2'd0,
    RES_RUN_REJECTED = 2'd1,
    RES_SPIN_READOUT = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    CFG_SPIN_COUNT    = 3'd0,
    CFG_STEP_COUNT    = 3'd1,
    CFG_PUMP_FINAL    = 3'd2,
    CFG_TIME_STEP     = 3'd3,
    CFG_COUPLING_GAIN = 3'd4,
    CFG_DAMPING_GAIN  = 3'd5
  } cfg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_SIGN_RD, ST_SIGN_WR, ST_ACC_RD, ST_ACC,
    ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8, ST_U9,
    ST_WB, ST_STEP_END, ST_READ, ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         row_index;
    logic [7:0]         column_index;
    logic signed [31:0] coupling_value;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] field_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [7:0]         spin_number;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
  } res_t;

  localparam logic signed [31:0] QOne    = 32'sd65536;
  localparam logic signed [31:0] QNegOne = -32'sd65536;

  // saturate a 49-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sh7fffffff) return 32'sh7fffffff;
    if (v < -49'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(49'(a) + 49'(b));
  endfunction

  // product shifted right 16 (floor), saturated
  function automatic logic signed [31:0] qshift(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sh7fffffff) return 32'sh7fffffff;
    if (s < -48'sh80000000) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

@@ rtl/simulated_bifurcation_ising_solver_top.sv @@
// Top level of the simulated bifurcation Ising solver.
// Depends on sbis_pkg; holds coupling and spin memories and the sequencer.
//
// Usage: write the registers, load couplings and spins (one cycle each),
// then start a run; busy stays high until a single result strobe. A run
// keeps busy high through the serial pump-increment divide, then per step
// a sign pass (a read and a write state per spin) and an update per spin,
// paced by the single coupling memory read port (one coupling per cycle)
// and the shared multiplier used seven times per spin update, and then
// the result state. A rejected run goes straight to the result state.
// Loads give no result and do not raise busy; a read passes through the
// read state and gives its strobe from the result register.
// Results are shown for one cycle only: the receiver cannot stall them.
module simulated_bifurcation_ising_solver_top #(
  parameter int MAX_SPINS = sbis_pkg::MaxSpinsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sbis_pkg::req_t req_i,
  output logic           res_valid_o,
  output sbis_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  localparam int IW = $clog2(MAX_SPINS);
  localparam int CW = IW + 1;

  // configuration
  logic [8:0] spin_count_q;
  logic [15:0] step_count_q;
  logic signed [31:0] pump_final_q, time_step_q, coupling_gain_q, damping_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_count_q <= '0; step_count_q <= '0; pump_final_q <= '0;
      time_step_q <= '0; coupling_gain_q <= '0; damping_gain_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sbis_pkg::CFG_SPIN_COUNT:    spin_count_q <= cfg_data_i[8:0];
        sbis_pkg::CFG_STEP_COUNT:    step_count_q <= cfg_data_i[15:0];
        sbis_pkg::CFG_PUMP_FINAL:    pump_final_q <= cfg_data_i;
        sbis_pkg::CFG_TIME_STEP:     time_step_q <= cfg_data_i;
        sbis_pkg::CFG_COUPLING_GAIN: coupling_gain_q <= cfg_data_i;
        sbis_pkg::CFG_DAMPING_GAIN:  damping_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  sbis_pkg::state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, k_q, k_d;
  logic [15:0] step_q, step_d;
  logic [5:0] div_cnt_q, div_cnt_d;

  // datapath registers
  logic signed [31:0] pump_now_q, pump_now_d, da_q, da_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvd_q, dvd_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, t_q, t_d, u_q, u_d;
  logic signed [31:0] p_a_q, p_a_d, p_b_q, p_b_d;
  logic signed [63:0] prod_q;
  sbis_pkg::res_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  logic [7:0] rd_row_q, rd_row_d;

  // memories
  logic signed [31:0] cmem [2**(2*IW)];
  logic signed [31:0] xmem [MAX_SPINS];
  logic signed [31:0] ymem [MAX_SPINS];
  logic signed [31:0] fmem [MAX_SPINS];
  logic smem [MAX_SPINS];

  logic [2*IW-1:0] c_raddr;
  logic [IW-1:0] s_raddr, sg_raddr, s_waddr;
  logic signed [31:0] c_rdata, x_rdata, y_rdata, f_rdata;
  logic sg_rdata;
  logic s_we, sg_we;
  logic signed [31:0] x_wdata, y_wdata;

  logic accept;
  logic row_ok, col_ok;
  logic run_bad;
  assign accept = start && !busy;
  assign row_ok = int'(req_i.row_index) < MAX_SPINS;
  assign col_ok = int'(req_i.column_index) < MAX_SPINS;
  assign run_bad = spin_count_q == 0 || int'(spin_count_q) > MAX_SPINS ||
                   step_count_q == 0;

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == sbis_pkg::REQ_LOAD_COUPLING && row_ok && col_ok)
      cmem[{IW'(req_i.row_index), IW'(req_i.column_index)}] <= req_i.coupling_value;
    c_rdata <= cmem[c_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == sbis_pkg::REQ_LOAD_SPIN && row_ok) begin
      xmem[IW'(req_i.row_index)] <= req_i.x_value;
      ymem[IW'(req_i.row_index)] <= req_i.y_value;
      fmem[IW'(req_i.row_index)] <= req_i.field_value;
    end else if (s_we) begin
      xmem[s_waddr] <= x_wdata;
      ymem[s_waddr] <= y_wdata;
    end
    x_rdata <= xmem[s_raddr];
    y_rdata <= ymem[s_raddr];
    f_rdata <= fmem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sg_we) smem[s_waddr] <= x_rdata >= 0;
    sg_rdata <= smem[sg_raddr];
  end

  // shared multiplier, registered
  always_ff @(posedge clk_i) prod_q <= p_a_q * p_b_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbis_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            sbis_pkg::REQ_RUN:
              if (run_bad) state_d = sbis_pkg::ST_DONE;
              else state_d = sbis_pkg::ST_DIV;
            sbis_pkg::REQ_READ_SPIN: state_d = sbis_pkg::ST_READ;
            default: state_d = sbis_pkg::ST_IDLE;
          endcase
        end
      end
      sbis_pkg::ST_DIV: if (div_cnt_q == 6'd33) state_d = sbis_pkg::ST_SIGN_RD;
      sbis_pkg::ST_SIGN_RD: state_d = sbis_pkg::ST_SIGN_WR;
      sbis_pkg::ST_SIGN_WR:
        state_d = (9'(i_q) + 9'd1 == spin_count_q) ? sbis_pkg::ST_ACC_RD
                                                   : sbis_pkg::ST_SIGN_RD;
      sbis_pkg::ST_ACC_RD: state_d = sbis_pkg::ST_ACC;
      sbis_pkg::ST_ACC: if (9'(k_q) == spin_count_q) state_d = sbis_pkg::ST_U1;
      sbis_pkg::ST_U1: state_d = sbis_pkg::ST_U2;
      sbis_pkg::ST_U2: state_d = sbis_pkg::ST_U3;
      sbis_pkg::ST_U3: state_d = sbis_pkg::ST_U4;
      sbis_pkg::ST_U4: state_d = sbis_pkg::ST_U5;
      sbis_pkg::ST_U5: state_d = sbis_pkg::ST_U6;
      sbis_pkg::ST_U6: state_d = sbis_pkg::ST_U7;
      sbis_pkg::ST_U7: state_d = sbis_pkg::ST_U8;
      sbis_pkg::ST_U8: state_d = sbis_pkg::ST_U9;
      sbis_pkg::ST_U9: state_d = sbis_pkg::ST_WB;
      sbis_pkg::ST_WB:
        state_d = (9'(i_q) + 9'd1 == spin_count_q) ? sbis_pkg::ST_STEP_END
                                                   : sbis_pkg::ST_ACC_RD;
      sbis_pkg::ST_STEP_END:
        state_d = (step_q + 16'd1 == step_count_q) ? sbis_pkg::ST_DONE
                                                   : sbis_pkg::ST_SIGN_RD;
      sbis_pkg::ST_READ: state_d = sbis_pkg::ST_IDLE;
      sbis_pkg::ST_DONE: state_d = sbis_pkg::ST_IDLE;
      default: state_d = sbis_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic signed [31:0] cv, sx, ny;
    logic [32:0] trial;
    logic signed [48:0] sum;
    i_d = i_q; k_d = k_q; step_d = step_q; div_cnt_d = div_cnt_q;
    pump_now_d = pump_now_q; da_d = da_q; rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q;
    acc_d = acc_q; x_d = x_q; y_d = y_q; t_d = t_q; u_d = u_q;
    p_a_d = p_a_q; p_b_d = p_b_q;
    res_valid_d = 1'b0; res_d = res_q; rd_row_d = rd_row_q;
    c_raddr = {i_q[IW-1:0], k_q[IW-1:0]};
    s_raddr = i_q[IW-1:0];
    sg_raddr = k_q[IW-1:0];
    s_waddr = i_q[IW-1:0];
    s_we = 1'b0; sg_we = 1'b0;
    x_wdata = x_q; y_wdata = u_q;
    cv = '0; sx = '0; ny = '0; trial = '0; sum = '0;
    case (state_q)
      sbis_pkg::ST_IDLE: begin
        i_d = '0; k_d = '0; step_d = '0; div_cnt_d = '0;
        rd_row_d = req_i.row_index;
        s_raddr = IW'(req_i.row_index);
        dvd_d = pump_final_q[31] ? 32'(-pump_final_q) : pump_final_q;
        rem_d = '0; quo_d = '0;
        if (accept && req_i.req_type == sbis_pkg::REQ_RUN) begin
          pump_now_d = '0;
          res_d = '0;
          res_d.result_kind = run_bad ? sbis_pkg::RES_RUN_REJECTED
                                      : sbis_pkg::RES_RUN_DONE;
        end
      end
      // restoring divide of |a0| by step_count, one bit a cycle
      sbis_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q < 6'd32) begin
          trial = {rem_q, dvd_q[31]};
          dvd_d = {dvd_q[30:0], 1'b0};
          if (trial >= 33'(step_count_q)) begin
            rem_d = 32'(trial - 33'(step_count_q)); quo_d = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = trial[31:0]; quo_d = {quo_q[30:0], 1'b0};
          end
        end else begin
          da_d = pump_final_q[31] ? 32'(-quo_q) : quo_q;
        end
      end
      sbis_pkg::ST_SIGN_RD: ;
      sbis_pkg::ST_SIGN_WR: begin
        sg_we = 1'b1;
        i_d = (9'(i_q) + 9'd1 == spin_count_q) ? '0 : i_q + 1'b1;
      end
      sbis_pkg::ST_ACC_RD: begin
        k_d = k_q + 1'b1;
      end
      // one coupling per cycle; data from read issued the cycle before
      sbis_pkg::ST_ACC: begin
        if (9'(k_q) < spin_count_q) k_d = k_q + 1'b1;
        if (k_q == CW'(1)) acc_d = 48'(f_rdata);
        cv = c_rdata;
        sum = (k_q == CW'(1)) ? 49'(f_rdata) : 49'(acc_q);
        sum = sg_rdata ? sum + 49'(cv) : sum - 49'(cv);
        if (sum > 49'sh7fffffffffff) acc_d = 48'sh7fffffffffff;
        else if (sum < -49'sh800000000000) acc_d = 48'sh800000000000;
        else acc_d = sum[47:0];
        x_d = x_rdata; y_d = y_rdata;
        p_a_d = sbis_pkg::sat32(49'(pump_now_q) - 49'(pump_final_q));
        p_b_d = x_rdata;
      end
      sbis_pkg::ST_U1: begin
        sx = sbis_pkg::sat32(49'(acc_q));
        p_a_d = coupling_gain_q; p_b_d = sx;
      end
      sbis_pkg::ST_U2: t_d = sbis_pkg::qshift(prod_q);
      sbis_pkg::ST_U3: begin
        p_a_d = sbis_pkg::qadd(t_q, sbis_pkg::qshift(prod_q)); p_b_d = time_step_q;
      end
      sbis_pkg::ST_U4: begin
        p_a_d = damping_gain_q; p_b_d = y_q;
      end
      sbis_pkg::ST_U5: begin
        ny = sbis_pkg::qadd(y_q, sbis_pkg::qshift(prod_q));
        u_d = ny;
        p_a_d = pump_final_q; p_b_d = ny;
      end
      sbis_pkg::ST_U6: begin
        p_a_d = sbis_pkg::qshift(prod_q); p_b_d = time_step_q;
      end
      sbis_pkg::ST_U7: begin
        p_a_d = sbis_pkg::qshift(prod_q); p_b_d = time_step_q;
      end
      // damping term gamma*y_old*dt arrives first
      sbis_pkg::ST_U8: t_d = sbis_pkg::qshift(prod_q);
      // position update, clamp, then momentum plus damping term
      sbis_pkg::ST_U9: begin
        sx = sbis_pkg::qadd(x_q, sbis_pkg::qshift(prod_q));
        if (sx > sbis_pkg::QOne || sx < sbis_pkg::QNegOne) begin
          x_d = sx[31] ? sbis_pkg::QNegOne : sbis_pkg::QOne; u_d = t_q;
        end else begin
          x_d = sx; u_d = sbis_pkg::qadd(u_q, t_q);
        end
      end
      sbis_pkg::ST_WB: begin
        s_we = 1'b1;
        k_d = '0;
        i_d = (9'(i_q) + 9'd1 == spin_count_q) ? '0 : i_q + 1'b1;
        s_raddr = i_d[IW-1:0];
      end
      sbis_pkg::ST_STEP_END: begin
        pump_now_d = sbis_pkg::qadd(pump_now_q, da_q);
        step_d = step_q + 16'd1;
      end
      sbis_pkg::ST_READ: begin
        res_valid_d = 1'b1;
        res_d.result_kind = sbis_pkg::RES_SPIN_READOUT;
        res_d.spin_number = rd_row_q;
        res_d.x_out = (int'(rd_row_q) < MAX_SPINS) ? x_rdata : '0;
        res_d.y_out = (int'(rd_row_q) < MAX_SPINS) ? y_rdata : '0;
      end
      sbis_pkg::ST_DONE: res_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbis_pkg::ST_IDLE;
      i_q <= '0; k_q <= '0; step_q <= '0; div_cnt_q <= '0;
      pump_now_q <= '0; res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; k_q <= k_d; step_q <= step_d; div_cnt_q <= div_cnt_d;
      pump_now_q <= pump_now_d; res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    da_q <= da_d; rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d;
    acc_q <= acc_d; x_q <= x_d; y_q <= y_d; t_q <= t_d; u_q <= u_d;
    p_a_q <= p_a_d; p_b_q <= p_b_d; res_q <= res_d; rd_row_q <= rd_row_d;
  end

  assign busy = state_q != sbis_pkg::ST_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
endmodule

@@ verif/sbis_checker.sv @@
// Checker for the simulated bifurcation Ising solver: watches the request,
// result and register channels, predicts every result and compares it.
// Depends on sbis_pkg for the payload types and codes.
`timescale 1ns / 100ps

module sbis_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  sbis_pkg::req_t req_i,
  input  logic           res_valid_o,
  input  sbis_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output int             fail_count,
  output int             pending_count
);
  localparam longint AccMax = 64'sd140737488355327;
  localparam longint AccMin = -AccMax - 1;

  // predictor copy of the solver state and registers
  logic signed [31:0] coupling_mem [65536];
  logic signed [31:0] pos_mem [256];
  logic signed [31:0] mom_mem [256];
  logic signed [31:0] field_mem [256];
  bit                 sign_mem [256];
  logic signed [31:0] pump_level;
  logic [8:0]         n_spins;
  logic [15:0]        n_steps;
  logic signed [31:0] a0, dt, c0, gamma;

  sbis_pkg::res_t solver_results_q [$];

  assign pending_count = solver_results_q.size();

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  // product floored by 2^16, then saturated
  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> 16);
  endfunction

  // full run: step_count sweeps over all spins in use
  task automatic solve_ising();
    logic signed [31:0] da, x, y_old, y_new, x_new, h;
    longint acc, jv;
    da = clip32(longint'(a0) / longint'(n_steps));
    pump_level = '0;
    for (int s = 0; s < n_steps; s++) begin
      for (int i = 0; i < n_spins; i++) sign_mem[i] = (pos_mem[i] >= 0);
      for (int i = 0; i < n_spins; i++) begin
        acc = longint'(field_mem[i]);
        for (int k = 0; k < n_spins; k++) begin
          jv = longint'(coupling_mem[i*256 + k]);
          acc = acc + (sign_mem[k] ? jv : -jv);
          if (acc > AccMax) acc = AccMax;
          if (acc < AccMin) acc = AccMin;
        end
        h = clip32(acc);
        x = pos_mem[i];
        y_old = mom_mem[i];
        y_new = q_add(y_old, q_mul(q_add(q_mul(q_sub(pump_level, a0), x),
                                         q_mul(c0, h)), dt));
        x_new = q_add(x, q_mul(q_mul(a0, y_new), dt));
        if (x_new > sbis_pkg::QOne || x_new < sbis_pkg::QNegOne) begin
          x_new = (x_new >= 0) ? sbis_pkg::QOne : sbis_pkg::QNegOne;
          y_new = '0;
        end
        pos_mem[i] = x_new;
        mom_mem[i] = q_add(y_new, q_mul(q_mul(gamma, y_old), dt));
      end
      pump_level = q_add(pump_level, da);
    end
  endtask

  // one accepted request transaction
  task automatic predict(input sbis_pkg::req_t r);
    sbis_pkg::res_t e;
    e = '0;
    case (r.req_type)
      sbis_pkg::REQ_LOAD_COUPLING:
        coupling_mem[r.row_index*256 + r.column_index] = r.coupling_value;
      sbis_pkg::REQ_LOAD_SPIN: begin
        pos_mem[r.row_index]   = r.x_value;
        mom_mem[r.row_index]   = r.y_value;
        field_mem[r.row_index] = r.field_value;
      end
      sbis_pkg::REQ_RUN: begin
        if (n_spins == 0 || n_spins > 256 || n_steps == 0) begin
          e.result_kind = sbis_pkg::RES_RUN_REJECTED;
        end else begin
          solve_ising();
          e.result_kind = sbis_pkg::RES_RUN_DONE;
        end
        solver_results_q.push_back(e);
      end
      default: begin
        e.result_kind = sbis_pkg::RES_SPIN_READOUT;
        e.spin_number = r.row_index;
        e.x_out       = pos_mem[r.row_index];
        e.y_out       = mom_mem[r.row_index];
        solver_results_q.push_back(e);
      end
    endcase
  endtask

  // result transaction against the oldest prediction
  task automatic compare(input sbis_pkg::res_t got);
    sbis_pkg::res_t want;
    if (solver_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: unexpected result kind=%0d spin=%0d x=%h y=%h",
                 got.result_kind, got.spin_number, got.x_out, got.y_out);
      return;
    end
    want = solver_results_q.pop_front();
    if (got.result_kind !== want.result_kind || got.spin_number !== want.spin_number ||
        got.x_out !== want.x_out || got.y_out !== want.y_out) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"ERROR: result mismatch exp kind=%0d spin=%0d x=%h y=%h, ",
                  "got kind=%0d spin=%0d x=%h y=%h"},
                 want.result_kind, want.spin_number, want.x_out, want.y_out,
                 got.result_kind, got.spin_number, got.x_out, got.y_out);
    end
  endtask

  initial begin
    fail_count = 0;
    pump_level = '0;
    n_spins = '0;
    n_steps = '0;
    a0 = '0;
    dt = '0;
    c0 = '0;
    gamma = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) compare(res_o);
      if (cfg_we_i) begin
        case (sbis_pkg::cfg_index_e'(cfg_index_i))
          sbis_pkg::CFG_SPIN_COUNT:    n_spins = cfg_data_i[8:0];
          sbis_pkg::CFG_STEP_COUNT:    n_steps = cfg_data_i[15:0];
          sbis_pkg::CFG_PUMP_FINAL:    a0 = cfg_data_i;
          sbis_pkg::CFG_TIME_STEP:     dt = cfg_data_i;
          sbis_pkg::CFG_COUPLING_GAIN: c0 = cfg_data_i;
          sbis_pkg::CFG_DAMPING_GAIN:  gamma = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) predict(req_i);
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the solver testbench: clock, reset, register writes and request
// stimulus. Depends on sbis_pkg, the solver top and sbis_checker.
`timescale 1ns / 100ps

module testbench;
  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sbis_pkg::req_t req_i = '0;
  logic           res_valid_o;
  sbis_pkg::res_t res_o;
  logic           cfg_we_i = 1'b0;
  logic [2:0]     cfg_index_i = '0;
  logic [31:0]    cfg_data_i = '0;
  int             fail_count;
  int             pending_count;
  int             cycle_count = 0;
  int             item_count = 0;

  // which stored entries have been written since reset
  bit coupling_loaded [65536];
  bit spin_loaded [256];

  simulated_bifurcation_ising_solver_top u_dut (.*);

  sbis_checker u_checker (.*);

  always #4 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 3000000) begin
      $display("simulated_bifurcation_ising_solver_top verification failed");
      $finish;
    end
  end

  // random gap after a transaction: mostly none or short, a few long
  task automatic pause();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // one request transaction; start stays high until the caller idles
  task automatic issue(input sbis_pkg::req_type_e kind, input int row, input int col,
                       input logic [31:0] cv, input logic [31:0] xv,
                       input logic [31:0] yv, input logic [31:0] fv);
    sbis_pkg::req_t r;
    r.req_type       = kind;
    r.row_index      = row[7:0];
    r.column_index   = col[7:0];
    r.coupling_value = cv;
    r.x_value        = xv;
    r.y_value        = yv;
    r.field_value    = fv;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    item_count++;
    if (kind == sbis_pkg::REQ_LOAD_COUPLING) coupling_loaded[row*256 + col] = 1'b1;
    if (kind == sbis_pkg::REQ_LOAD_SPIN) spin_loaded[row] = 1'b1;
    pause();
  endtask

  // wait until every predicted result has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending_count != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  // write enable stays high across back-to-back writes; write_all drops it
  task automatic write_reg(input sbis_pkg::cfg_index_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic write_all(input int n, input int steps, input logic [31:0] pf,
                           input logic [31:0] ts, input logic [31:0] cg,
                           input logic [31:0] dg);
    drain();
    write_reg(sbis_pkg::CFG_SPIN_COUNT, n);
    write_reg(sbis_pkg::CFG_STEP_COUNT, steps);
    write_reg(sbis_pkg::CFG_PUMP_FINAL, pf);
    write_reg(sbis_pkg::CFG_TIME_STEP, ts);
    write_reg(sbis_pkg::CFG_COUPLING_GAIN, cg);
    write_reg(sbis_pkg::CFG_DAMPING_GAIN, dg);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Q16.16 value: mostly within a few units, sometimes any 32 bits
  function automatic logic [31:0] rand_q(input bit wide);
    if (wide) return $urandom;
    return 32'($urandom_range(0, 4*65536)) - 32'd131072;
  endfunction

  function automatic int loaded_spin();
    int s;
    do s = $urandom_range(0, 255); while (!spin_loaded[s]);
    return s;
  endfunction

  // load/run/read sequence: fill what a run of n spins needs, run, read back; with reject set the run is rejected
  task automatic solve_phase(input int n, input bit wide, input bit reject);
    int steps;
    steps = $urandom_range(1, 6);
    if (reject) begin
      case ($urandom_range(0, 2))
        0: write_all(0, steps, rand_q(wide), rand_q(wide), rand_q(wide), rand_q(wide));
        1: write_all($urandom_range(257, 511), steps, rand_q(wide), rand_q(wide),
                     rand_q(wide), rand_q(wide));
        default: write_all(n, 0, rand_q(wide), rand_q(wide), rand_q(wide), rand_q(wide));
      endcase
    end else begin
      write_all(n, steps, rand_q(wide), rand_q(wide), rand_q(wide), rand_q(wide));
    end
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++)
        if (!coupling_loaded[i*256 + k] || $urandom_range(0, 1))
          issue(sbis_pkg::REQ_LOAD_COUPLING, i, k, rand_q(wide), $urandom, $urandom,
                $urandom);
      if (!spin_loaded[i] || $urandom_range(0, 1))
        issue(sbis_pkg::REQ_LOAD_SPIN, i, $urandom_range(0, 255), $urandom, rand_q(wide),
              rand_q(wide), rand_q(wide));
      // noise: stray loads and reads between the useful ones
      if ($urandom_range(0, 9) == 0)
        issue(sbis_pkg::req_type_e'($urandom_range(0, 1)), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 9) == 0)
        issue(sbis_pkg::REQ_READ_SPIN, loaded_spin(), $urandom_range(0, 255), $urandom,
              $urandom, $urandom, $urandom);
    end
    issue(sbis_pkg::REQ_RUN, $urandom_range(0, 255), $urandom_range(0, 255), $urandom,
          $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 3) != 0)
        issue(sbis_pkg::REQ_READ_SPIN, i, $urandom_range(0, 255), $urandom, $urandom,
              $urandom, $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: rejected runs, field extremes, saturating settings
    write_all(0, 1, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_1000);
    issue(sbis_pkg::REQ_RUN, 255, 255, '1, '1, '1, '1);
    write_all(2, 0, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_1000);
    issue(sbis_pkg::REQ_RUN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_LOAD_COUPLING, 0, 0, 32'h7fff_ffff, '0, '0, '0);
    issue(sbis_pkg::REQ_LOAD_COUPLING, 0, 1, 32'h8000_0000, '0, '0, '0);
    issue(sbis_pkg::REQ_LOAD_COUPLING, 1, 0, 32'hffff_ffff, '0, '0, '0);
    issue(sbis_pkg::REQ_LOAD_COUPLING, 1, 1, 32'h0000_0000, '0, '0, '0);
    issue(sbis_pkg::REQ_LOAD_COUPLING, 255, 255, 32'h0001_0000, '1, '1, '1);
    issue(sbis_pkg::REQ_LOAD_SPIN, 0, 0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    issue(sbis_pkg::REQ_LOAD_SPIN, 1, 255, '1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    issue(sbis_pkg::REQ_LOAD_SPIN, 255, 0, '0, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001);
    issue(sbis_pkg::REQ_READ_SPIN, 255, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 0, 255, '1, '1, '1, '1);
    write_all(2, 1, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_1000);
    issue(sbis_pkg::REQ_RUN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 1, 0, '0, '0, '0, '0);
    write_all(2, 3, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    issue(sbis_pkg::REQ_RUN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 1, 0, '0, '0, '0, '0);
    write_all(511, 65535, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    issue(sbis_pkg::REQ_RUN, 0, 0, '0, '0, '0, '0);

    // random: mostly well-formed load/run/read sequences
    while (item_count < 1150)
      solve_phase($urandom_range(1, 8), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 7) == 0);

    // one larger run over a 16 by 16 matrix, single step
    write_all(16, 1, rand_q(0), rand_q(0), rand_q(0), rand_q(0));
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 16; k++)
        if (!coupling_loaded[i*256 + k])
          issue(sbis_pkg::REQ_LOAD_COUPLING, i, k, rand_q(0), '0, '0, '0);
      if (!spin_loaded[i])
        issue(sbis_pkg::REQ_LOAD_SPIN, i, 0, '0, rand_q(0), rand_q(0), rand_q(0));
    end
    issue(sbis_pkg::REQ_RUN, 0, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, 255, 0, '0, '0, '0, '0);
    issue(sbis_pkg::REQ_READ_SPIN, loaded_spin(), 0, '0, '0, '0, '0);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulated_bifurcation_ising_solver_top verification clean");
    end else begin
      $display("simulated_bifurcation_ising_solver_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sbis_pkg.sv
rtl/simulated_bifurcation_ising_solver_top.sv
verif/sbis_checker.sv
verif/testbench.sv
